// File: rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and codes for the UTF-8 validating decode and search unit.
// ----------------------------------------------------------------------------
package u8dec_pkg;

	typedef enum logic [0:0] {
		CFG_SEARCH_CP = 1'b0,
		CFG_TARGET    = 1'b1
	} cfg_idx_t;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_CP    = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	localparam logic [1:0] END_NONE  = 2'd0;
	localparam logic [1:0] END_CLEAN = 2'd1;
	localparam logic [1:0] END_ERROR = 2'd2;
	localparam logic [1:0] END_TRUNC = 2'd3;

	// byte classes seen by the decode DFA
	typedef enum logic [3:0] {
		BC_ASCII   = 4'd0,   // 00-7F
		BC_CONT_LO = 4'd1,   // 80-8F
		BC_CONT_MD = 4'd2,   // 90-9F
		BC_CONT_HI = 4'd3,   // A0-BF
		BC_LEAD2   = 4'd4,   // C2-DF
		BC_E0      = 4'd5,
		BC_ED      = 4'd6,
		BC_E_OTHER = 4'd7,   // E1-EC, EE, EF
		BC_F0      = 4'd8,
		BC_F1_F3   = 4'd9,
		BC_F4      = 4'd10,
		BC_BAD     = 4'd11   // C0, C1, F5-FF
	} byte_cls_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_of_buffer;
		logic        last_of_buffer;
		logic [31:0] base_offset;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [20:0] codepoint;
		logic        is_match;
		logic        found;
		logic [31:0] ok_count;
		logic [31:0] error_count;
		logic [31:0] match_count;
		logic [31:0] sequence_count;
		logic [31:0] sequence_start_offset;
		logic [31:0] next_offset;
		logic [1:0]  end_status;
	} out_word_t;

	// classified byte handed from front to back
	typedef struct packed {
		byte_cls_t   cls;
		logic [6:0]  payload;
		logic        first_of_buffer;
		logic        last_of_buffer;
		logic [31:0] base_offset;
	} cls_word_t;

	typedef struct packed {
		logic [20:0] search_codepoint;
		logic [31:0] occurrence_target;
	} cfg_t;

endpackage

// File: rtl/u8dec_front.sv
// ----------------------------------------------------------------------------
// u8dec_front
// Accepts input words, classifies each byte and extracts its payload bits.
// ----------------------------------------------------------------------------
module u8dec_front
	import u8dec_pkg::*;
(
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      push,
	output cls_word_t push_data,
	input  logic      q_full
);

	function automatic byte_cls_t classify(input logic [7:0] b);
		byte_cls_t c;
		if (b inside {[8'h00:8'h7F]})       c = BC_ASCII;
		else if (b inside {[8'h80:8'h8F]})  c = BC_CONT_LO;
		else if (b inside {[8'h90:8'h9F]})  c = BC_CONT_MD;
		else if (b inside {[8'hA0:8'hBF]})  c = BC_CONT_HI;
		else if (b inside {[8'hC2:8'hDF]})  c = BC_LEAD2;
		else if (b == 8'hE0)                c = BC_E0;
		else if (b == 8'hED)                c = BC_ED;
		else if (b inside {[8'hE1:8'hEF]})  c = BC_E_OTHER;
		else if (b == 8'hF0)                c = BC_F0;
		else if (b inside {[8'hF1:8'hF3]})  c = BC_F1_F3;
		else if (b == 8'hF4)                c = BC_F4;
		else                                c = BC_BAD;
		return c;
	endfunction

	function automatic logic [6:0] payload_bits(input logic [7:0] b);
		logic [6:0] p;
		if (b <= 8'h7F)      p = b[6:0];
		else if (b <= 8'hBF) p = {1'b0, b[5:0]};
		else if (b <= 8'hDF) p = {2'b0, b[4:0]};
		else if (b <= 8'hEF) p = {3'b0, b[3:0]};
		else                 p = {4'b0, b[2:0]};
		return p;
	endfunction

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_data.cls             = classify(in_data.data_byte);
		push_data.payload         = payload_bits(in_data.data_byte);
		push_data.first_of_buffer = in_data.first_of_buffer;
		push_data.last_of_buffer  = in_data.last_of_buffer;
		push_data.base_offset     = in_data.base_offset;
	end

endmodule

// File: rtl/u8dec_queue.sv
// ----------------------------------------------------------------------------
// u8dec_queue
// Two-word queue between the classify front and the decode back.
// ----------------------------------------------------------------------------
module u8dec_queue
	import u8dec_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_word_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      avail,
	output cls_word_t pop_data
);

	cls_word_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign avail    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/u8dec_back.sv
// ----------------------------------------------------------------------------
// u8dec_back
// Runs the UTF-8 DFA, rebuilds codepoints, keeps counters and offsets, and
// holds the output register.
// ----------------------------------------------------------------------------
module u8dec_back
	import u8dec_pkg::*;
#(
	parameter int COUNT_WIDTH  = 32,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      avail,
	input  cls_word_t pop_data,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	typedef enum logic [3:0] {
		DS_START = 4'd0,
		DS_NEED1 = 4'd1,
		DS_NEED2 = 4'd2,
		DS_ED    = 4'd3,
		DS_NEED3 = 4'd4,
		DS_F4    = 4'd5,
		DS_E0    = 4'd6,
		DS_F0    = 4'd7,
		DS_ERR   = 4'd8
	} dec_state_t;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	function automatic dec_state_t next_state(input dec_state_t st, input byte_cls_t c);
		dec_state_t n;
		logic any_cont;
		any_cont = (c == BC_CONT_LO) || (c == BC_CONT_MD) || (c == BC_CONT_HI);
		n = DS_ERR;
		case (st)
			DS_START: begin
				case (c)
					BC_ASCII:   n = DS_START;
					BC_LEAD2:   n = DS_NEED1;
					BC_E0:      n = DS_E0;
					BC_ED:      n = DS_ED;
					BC_E_OTHER: n = DS_NEED2;
					BC_F0:      n = DS_F0;
					BC_F1_F3:   n = DS_NEED3;
					BC_F4:      n = DS_F4;
					default:    n = DS_ERR;
				endcase
			end
			DS_NEED1: n = any_cont ? DS_START : DS_ERR;
			DS_NEED2: n = any_cont ? DS_NEED1 : DS_ERR;
			DS_ED:    n = (c == BC_CONT_LO || c == BC_CONT_MD) ? DS_NEED1 : DS_ERR;
			DS_NEED3: n = any_cont ? DS_NEED2 : DS_ERR;
			DS_F4:    n = (c == BC_CONT_LO) ? DS_NEED2 : DS_ERR;
			DS_E0:    n = (c == BC_CONT_HI) ? DS_NEED1 : DS_ERR;
			DS_F0:    n = (c == BC_CONT_MD || c == BC_CONT_HI) ? DS_NEED2 : DS_ERR;
			default:  n = DS_ERR;
		endcase
		return n;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	dec_state_t              state_q;
	logic [20:0]             acc_q;
	logic [COUNT_WIDTH-1:0]  good_q, bad_q, hit_q;
	logic [31:0]             rem_q;
	logic [OFFSET_WIDTH-1:0] pos_q, start_q;
	logic                    done_q;
	logic                    out_valid_q;
	out_word_t               out_q;

	dec_state_t              st_e, st_n, ns;
	logic [20:0]             acc_e, acc_n, acc_upd;
	logic [COUNT_WIDTH-1:0]  good_e, good_n, bad_e, bad_n, hit_e, hit_n;
	logic [31:0]             rem_e, rem_n;
	logic [OFFSET_WIDTH-1:0] pos_e, pos_n, start_e, start_n, after;
	logic                    done_e, done_n;
	logic [COUNT_WIDTH:0]    seq_sum;
	logic [COUNT_WIDTH-1:0]  seq_tot;
	logic                    err_here;
	out_word_t               res;

	assign pop       = avail && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (pop_data.first_of_buffer) begin
			st_e    = DS_START;
			acc_e   = '0;
			good_e  = '0;
			bad_e   = '0;
			hit_e   = '0;
			rem_e   = cfg.occurrence_target;
			pos_e   = OFFSET_WIDTH'(pop_data.base_offset);
			start_e = OFFSET_WIDTH'(pop_data.base_offset);
			done_e  = 1'b0;
		end else begin
			st_e    = state_q;
			acc_e   = acc_q;
			good_e  = good_q;
			bad_e   = bad_q;
			hit_e   = hit_q;
			rem_e   = rem_q;
			pos_e   = pos_q;
			start_e = start_q;
			done_e  = done_q;
		end

		ns      = next_state(st_e, pop_data.cls);
		acc_upd = {acc_e[14:0], 6'b0} | {14'b0, pop_data.payload};
		after   = pos_e + 1'b1;

		st_n     = st_e;
		acc_n    = acc_e;
		good_n   = good_e;
		bad_n    = bad_e;
		hit_n    = hit_e;
		rem_n    = rem_e;
		pos_n    = pos_e;
		start_n  = start_e;
		done_n   = done_e;
		err_here = 1'b0;

		res                       = '0;
		res.sequence_start_offset = 32'(start_e);

		if (!done_e) begin
			pos_n = after;
			if (ns == DS_ERR) begin
				res.event_res = EV_ERROR;
				err_here      = 1'b1;
				bad_n         = sat_inc(bad_e);
				st_n          = DS_START;
				acc_n         = '0;
				start_n       = after;
			end else if (ns == DS_START) begin
				res.event_res = EV_CP;
				res.codepoint = acc_upd;
				good_n        = sat_inc(good_e);
				if (acc_upd == cfg.search_codepoint) begin
					res.is_match = 1'b1;
					hit_n        = sat_inc(hit_e);
					if (rem_e != '0) begin
						rem_n = rem_e - 1'b1;
						if (rem_e == 32'd1) begin
							res.found = 1'b1;
							done_n    = 1'b1;
						end
					end
				end
				st_n  = DS_START;
				acc_n = '0;
				if (!res.found) start_n = after;
			end else begin
				st_n  = ns;
				acc_n = acc_upd;
			end
		end

		if (pop_data.last_of_buffer) begin
			if (done_n)               res.end_status = END_CLEAN;
			else if (err_here)        res.end_status = END_ERROR;
			else if (st_n != DS_START) res.end_status = END_TRUNC;
			else                      res.end_status = END_CLEAN;
		end else begin
			res.end_status = END_NONE;
		end

		seq_sum = {1'b0, good_n} + {1'b0, bad_n};
		seq_tot = seq_sum[COUNT_WIDTH] ? CNT_MAX : seq_sum[COUNT_WIDTH-1:0];

		res.ok_count       = 32'(good_n);
		res.error_count    = 32'(bad_n);
		res.match_count    = 32'(hit_n);
		res.sequence_count = 32'(seq_tot);
		res.next_offset    = 32'(pos_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DS_START;
			acc_q       <= '0;
			good_q      <= '0;
			bad_q       <= '0;
			hit_q       <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			start_q     <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (pop) begin
				state_q     <= st_n;
				acc_q       <= acc_n;
				good_q      <= good_n;
				bad_q       <= bad_n;
				hit_q       <= hit_n;
				rem_q       <= rem_n;
				pos_q       <= pos_n;
				start_q     <= start_n;
				done_q      <= done_n;
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/utf8_validating_decode_search_unit.sv
// ----------------------------------------------------------------------------
// utf8_validating_decode_search_unit
// UTF-8 validating decoder with codepoint search, one byte per word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one stream byte per word
// with first/last-of-buffer marks and a base offset. Output channel
// (out_valid/out_stall/out_data) returns one result word per input word,
// in order. Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data)
// set search_codepoint (index 0) and occurrence_target (index 1); cfg_ready
// is always high.
// The front classifies each byte and writes it into a two-word queue; the
// back runs the DFA and counter update combinationally and loads the output
// register. Each byte passes through a queue entry and then the output
// register before its result word shows on out_valid/out_data;
// throughput is one byte per cycle while out_stall is low, set by the DFA,
// counter and offset update in the back.
// Reset clears the queue, decode state, counters, offsets and registers.
// While out_stall is high the result holds; the back stops popping, the
// queue fills within two words and in_stall then rises.
// ----------------------------------------------------------------------------
module utf8_validating_decode_search_unit
	import u8dec_pkg::*;
#(
	parameter int COUNT_WIDTH  = 32,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t      cfg_q;
	logic      push, q_full, q_avail, pop;
	cls_word_t push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEARCH_CP: cfg_q.search_codepoint  <= cfg_data[20:0];
				CFG_TARGET:    cfg_q.occurrence_target <= cfg_data;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	u8dec_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	u8dec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.avail     (q_avail),
		.pop_data  (pop_data)
	);

	u8dec_back #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.avail     (q_avail),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_found_is_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found |-> out_data.is_match && out_data.event_res == EV_CP)
		else $error("found without a completed matching codepoint");

	a_cp_only_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res != EV_CP |-> out_data.codepoint == '0 && !out_data.is_match)
		else $error("codepoint or match shown without a completed codepoint");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_avail)
		else $error("input stalled while the queue is empty");

	a_pop_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_avail && (!out_valid || !out_stall))
		else $error("queue popped without a free output slot");

endmodule
